### hdl/keyboard_matrix_port_unit_assert.svh
// Assertion macros for the keyboard matrix port unit.
// Included by the top level; no other dependencies.
`ifndef KEYBOARD_MATRIX_PORT_UNIT_ASSERT_SVH
`define KEYBOARD_MATRIX_PORT_UNIT_ASSERT_SVH
`ifndef SYNTH
// Check that cons holds in the same cycle as ante.
`define KMP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyboard matrix port check failed");
// Check that cons holds in the cycle after ante.
`define KMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyboard matrix port check failed");
`else
`define KMP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define KMP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/kmp_pkg.sv
// Shared types, constants and the key lookup table of the keyboard matrix port.
// No dependencies; used by the top level, the controller and the datapath.
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

   // Address window
   localparam int WINDOW_BASE = 3072;
   localparam int WINDOW_SIZE = 1024;
   localparam int INDEX_W     = $clog2(WINDOW_SIZE);

   localparam int         NUM_KEYS     = 78;
   localparam logic [10:0] DISTINCT_MAX = 11'd2047;
   localparam logic [31:0] ATTEMPT_MAX  = 32'hFFFF_FFFF;

   // Command codes
   localparam logic [2:0] CMD_READ  = 3'd0;
   localparam logic [2:0] CMD_PEEK  = 3'd1;
   localparam logic [2:0] CMD_KEY   = 3'd2;
   localparam logic [2:0] CMD_SET   = 3'd3;
   localparam logic [2:0] CMD_CLEAR = 3'd4;

   // Rows that read as idle even without a stored base byte
   localparam logic [15:0] IDLE_ROW_A = 16'h0DFF;
   localparam logic [15:0] IDLE_ROW_B = 16'h0F7F;
   localparam logic [15:0] IDLE_ROW_C = 16'h0FFE;
   localparam logic [7:0]  IDLE_BASE  = 8'hFF;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] bus_address;
      logic [7:0]  response_byte;
      logic        response_known;
      logic [6:0]  key_number;
      logic        key_down;
   } req_type;

   typedef struct packed {
      logic        handled;
      logic        value_valid;
      logic [7:0]  read_byte;
      logic        accepted;
      logic [31:0] attempt_count;
      logic [10:0] distinct_count;
   } rsp_type;

   // One entry of the per-address store
   typedef struct packed {
      logic [7:0] base;
      logic       known;
      logic [7:0] pressed;
   } store_word_type;

   typedef struct packed {
      logic [15:0] addr;
      logic [7:0]  mask;
   } key_entry_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic apply;
      logic sweep_all;
      logic sweep_vis;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_item;
      logic sweep_last;
   } ctrl_status_type;

   function automatic logic in_window(input logic [15:0] a);
      logic [16:0] ext;
      logic [16:0] off;
      ext = {1'b0, a};
      off = ext - 17'(WINDOW_BASE);
      return (ext >= 17'(WINDOW_BASE)) && (off < 17'(WINDOW_SIZE));
   endfunction

   function automatic logic [INDEX_W-1:0] win_index(input logic [15:0] a);
      return INDEX_W'(a - 16'(WINDOW_BASE));
   endfunction

   function automatic logic idle_verified(input logic [15:0] a);
      return (a == IDLE_ROW_A) || (a == IDLE_ROW_B) || (a == IDLE_ROW_C);
   endfunction

   // Key number to matrix row address and column bit
   function automatic key_entry_type key_lookup(input logic [6:0] k);
      key_entry_type e;
      case (k)
         7'd0:  e = '{16'h0DFF, 8'h08};  7'd1:  e = '{16'h0DFF, 8'h10};
         7'd2:  e = '{16'h0DFF, 8'h04};  7'd3:  e = '{16'h0F7F, 8'h40};
         7'd4:  e = '{16'h0FEF, 8'h01};  7'd5:  e = '{16'h0FFB, 8'h02};
         7'd6:  e = '{16'h0FEF, 8'h02};  7'd7:  e = '{16'h0F7F, 8'h01};
         7'd8:  e = '{16'h0F7F, 8'h08};  7'd9:  e = '{16'h0F7F, 8'h20};
         7'd10: e = '{16'h0F7F, 8'h10};  7'd11: e = '{16'h0FFE, 8'h01};
         7'd12: e = '{16'h0FFE, 8'h02};  7'd13: e = '{16'h0FFE, 8'h04};
         7'd14: e = '{16'h0FFE, 8'h08};  7'd15: e = '{16'h0FFE, 8'h10};
         7'd16: e = '{16'h0FFE, 8'h20};  7'd17: e = '{16'h0FFE, 8'h40};
         7'd18: e = '{16'h0FFE, 8'h80};  7'd19: e = '{16'h0F7F, 8'h80};
         7'd20: e = '{16'h0FF7, 8'h80};  7'd21: e = '{16'h0FFB, 8'h01};
         7'd22: e = '{16'h0FFB, 8'h04};  7'd23: e = '{16'h0FFB, 8'h08};
         7'd24: e = '{16'h0FFB, 8'h10};  7'd25: e = '{16'h0FFB, 8'h20};
         7'd26: e = '{16'h0FFB, 8'h40};  7'd27: e = '{16'h0FFB, 8'h80};
         7'd28: e = '{16'h0FF7, 8'h01};  7'd29: e = '{16'h0FF7, 8'h02};
         7'd30: e = '{16'h0FF7, 8'h20};  7'd31: e = '{16'h0FEF, 8'h04};
         7'd32: e = '{16'h0FEF, 8'h08};  7'd33: e = '{16'h0FEF, 8'h10};
         7'd34: e = '{16'h0FEF, 8'h20};  7'd35: e = '{16'h0FEF, 8'h40};
         7'd36: e = '{16'h0FEF, 8'h80};  7'd37: e = '{16'h0FDF, 8'h01};
         7'd38: e = '{16'h0FDF, 8'h02};  7'd39: e = '{16'h0FDF, 8'h04};
         7'd40: e = '{16'h0FDF, 8'h08};  7'd41: e = '{16'h0FDF, 8'h10};
         7'd42: e = '{16'h0FDF, 8'h20};  7'd43: e = '{16'h0FDF, 8'h40};
         7'd44: e = '{16'h0FDF, 8'h80};  7'd45: e = '{16'h0FBF, 8'h01};
         7'd46: e = '{16'h0FBF, 8'h02};  7'd47: e = '{16'h0FBF, 8'h04};
         7'd48: e = '{16'h0FBF, 8'h08};  7'd49: e = '{16'h0FBF, 8'h10};
         7'd50: e = '{16'h0FBF, 8'h20};  7'd51: e = '{16'h0FBF, 8'h40};
         7'd52: e = '{16'h0FBF, 8'h80};  7'd53: e = '{16'h0F7F, 8'h02};
         7'd54: e = '{16'h0F7F, 8'h04};  7'd55: e = '{16'h0FF7, 8'h04};
         7'd56: e = '{16'h0FF7, 8'h08};  7'd57: e = '{16'h0FF7, 8'h10};
         7'd58: e = '{16'h0FF7, 8'h40};  7'd59: e = '{16'h0EFF, 8'h01};
         7'd60: e = '{16'h0EFF, 8'h02};  7'd61: e = '{16'h0EFF, 8'h04};
         7'd62: e = '{16'h0EFF, 8'h08};  7'd63: e = '{16'h0EFF, 8'h10};
         7'd64: e = '{16'h0EFF, 8'h20};  7'd65: e = '{16'h0EFF, 8'h40};
         7'd66: e = '{16'h0EFF, 8'h80};  7'd67: e = '{16'h0DFF, 8'h01};
         7'd68: e = '{16'h0DFF, 8'h02};  7'd69: e = '{16'h0FFD, 8'h01};
         7'd70: e = '{16'h0FFD, 8'h02};  7'd71: e = '{16'h0FFD, 8'h04};
         7'd72: e = '{16'h0FFD, 8'h08};  7'd73: e = '{16'h0FFD, 8'h10};
         7'd74: e = '{16'h0FFD, 8'h20};  7'd75: e = '{16'h0FFD, 8'h40};
         7'd76: e = '{16'h0FFD, 8'h80};
         default: e = '{16'h0000, 8'h00};
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

### hdl/kmp_if.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on kmp_pkg for nothing but shares its field widths.
`timescale 1ns / 1ps
`default_nettype none

interface kmp_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [15:0] bus_address;
   logic [7:0]  response_byte;
   logic        response_known;
   logic [6:0]  key_number;
   logic        key_down;

   modport source (
      output valid, cmd, bus_address, response_byte, response_known, key_number,
         key_down,
      input  ready
   );
   modport sink (
      input  valid, cmd, bus_address, response_byte, response_known, key_number,
         key_down,
      output ready
   );
endinterface

interface kmp_rsp_if;
   logic        valid;
   logic        ready;
   logic        handled;
   logic        value_valid;
   logic [7:0]  read_byte;
   logic        accepted;
   logic [31:0] attempt_count;
   logic [10:0] distinct_count;

   modport source (
      output valid, handled, value_valid, read_byte, accepted, attempt_count,
         distinct_count,
      input  ready
   );
   modport sink (
      input  valid, handled, value_valid, read_byte, accepted, attempt_count,
         distinct_count,
      output ready
   );
endinterface

`default_nettype wire

### hdl/keyboard_matrix_port_unit.sv
// Top level of the keyboard matrix port: joins controller and datapath to
// the request and response channels. Depends on kmp_pkg, kmp_if, kmp_ctrl,
// kmp_datapath and the assertion macro header.
//
//   channel  | dir | handshake          | item
//   ---------+-----+--------------------+-----------------------------------
//   req_ch   | in  | valid/ready        | cmd, address, response, key event
//   rsp_ch   | out | valid/ready        | read value, accepted, counters
//
// One item at a time: accept launches the store and visited RAM reads, and
// the apply state then writes the entry back and loads the response register.
// A clear-activity item is followed by a sweep of all 1024 visited RAM entries.
// After reset a sweep of all 1024 entries clears both RAMs, with req_ch.ready low.
// A response left waiting holds the next item in its apply cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "keyboard_matrix_port_unit_assert.svh"

module keyboard_matrix_port_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   kmp_req_if.sink    req_ch,
   kmp_rsp_if.source  rsp_ch
);

   kmp_pkg::ctrl_cmd_type    ctrl_cmd;
   kmp_pkg::ctrl_status_type ctrl_status;
   kmp_pkg::req_type         req_item;
   kmp_pkg::rsp_type         rsp_item;

   // Gather the request payload
   always_comb begin
      req_item.cmd            = req_ch.cmd;
      req_item.bus_address    = req_ch.bus_address;
      req_item.response_byte  = req_ch.response_byte;
      req_item.response_known = req_ch.response_known;
      req_item.key_number     = req_ch.key_number;
      req_item.key_down       = req_ch.key_down;
   end

   kmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (ctrl_status),
      .cmd       (ctrl_cmd)
   );

   kmp_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (ctrl_cmd),
      .status (ctrl_status),
      .req    (req_item),
      .rsp    (rsp_item)
   );

   // Drive the response payload
   assign rsp_ch.handled        = rsp_item.handled;
   assign rsp_ch.value_valid    = rsp_item.value_valid;
   assign rsp_ch.read_byte      = rsp_item.read_byte;
   assign rsp_ch.accepted       = rsp_item.accepted;
   assign rsp_ch.attempt_count  = rsp_item.attempt_count;
   assign rsp_ch.distinct_count = rsp_item.distinct_count;

   // One item in flight at a time
   `KMP_ASSERT_NEXT(a_one_in_flight, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   // A determined value only comes from a handled read or peek
   `KMP_ASSERT_IMPLY(a_valid_handled, clock, reset, rsp_ch.valid && rsp_ch.value_valid,
      rsp_ch.handled)
   // Reads and writes never report both handled and accepted
   `KMP_ASSERT_IMPLY(a_excl_flags, clock, reset, rsp_ch.valid,
      !(rsp_ch.handled && rsp_ch.accepted))
   // Every distinct address read is also a counted attempt
   `KMP_ASSERT_IMPLY(a_distinct_le_attempts, clock, reset, rsp_ch.valid,
      32'(rsp_ch.distinct_count) <= rsp_ch.attempt_count)

endmodule

`default_nettype wire

### hdl/kmp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module kmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

### hdl/kmp_ctrl.sv
// Controller of the keyboard matrix port: sequences reset sweep, item
// accept, apply and the visited-flag sweep. Depends on kmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kmp_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire kmp_pkg::ctrl_status_type status,
   output kmp_pkg::ctrl_cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_SWEEP_ALL,
      ST_IDLE,
      ST_APPLY,
      ST_SWEEP_VIS
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Decode commands from the current state
   always_comb begin
      cmd.accept    = (state_ff == ST_IDLE) && req_valid;
      cmd.apply     = (state_ff == ST_APPLY) && out_free;
      cmd.sweep_all = (state_ff == ST_SWEEP_ALL);
      cmd.sweep_vis = (state_ff == ST_SWEEP_VIS);
   end

   // Next state and response valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_SWEEP_ALL, ST_SWEEP_VIS: begin
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = status.clear_item ? ST_SWEEP_VIS : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_SWEEP_ALL;
         end
      endcase
   end

   // Hold state and the response valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP_ALL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### hdl/kmp_datapath.sv
// Datapath of the keyboard matrix port: per-address store and visited RAMs,
// item capture, read value logic, activity counters and the response register.
// Depends on kmp_pkg and kmp_ram.
`timescale 1ns / 1ps
`default_nettype none

module kmp_datapath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire kmp_pkg::ctrl_cmd_type    cmd,
   output kmp_pkg::ctrl_status_type      status,
   input  wire kmp_pkg::req_type         req,
   output kmp_pkg::rsp_type              rsp
);

   localparam int IW = kmp_pkg::INDEX_W;
   localparam int SW = $bits(kmp_pkg::store_word_type);

   kmp_pkg::req_type        item_ff;
   logic [IW-1:0]           idx_ff;
   logic                    in_win_ff;
   logic [7:0]              key_bit_ff;
   logic [IW-1:0]           sweep_cnt_ff, sweep_cnt_in;
   logic [31:0]             attempts_ff, attempts_in;
   logic [10:0]             distinct_ff, distinct_in;
   kmp_pkg::rsp_type        rsp_ff, rsp_in;

   kmp_pkg::key_entry_type  key_ent;
   logic                    req_in_win;
   logic [IW-1:0]           req_idx;
   logic                    sweep_any, sweep_last;

   logic [SW-1:0]           store_rdata;
   logic [SW-1:0]           store_wdata;
   logic                    store_we;
   logic [IW-1:0]           store_waddr;
   logic                    vis_rdata;
   logic                    vis_we;
   logic                    vis_wdata;
   logic [IW-1:0]           vis_waddr;

   kmp_pkg::store_word_type st, st_new;
   logic                    is_rp, is_read, is_key, is_set, is_clear;
   logic                    single, verified, value_ok;
   logic [7:0]              base_sel;
   logic                    count_read;

   // Resolve the store index of an incoming item
   always_comb begin
      key_ent = kmp_pkg::key_lookup(req.key_number);
      if (req.cmd == kmp_pkg::CMD_KEY) begin
         req_in_win = (req.key_number < 7'(kmp_pkg::NUM_KEYS)) &&
            kmp_pkg::in_window(key_ent.addr);
         req_idx    = kmp_pkg::win_index(key_ent.addr);
      end else begin
         req_in_win = kmp_pkg::in_window(req.bus_address);
         req_idx    = kmp_pkg::win_index(req.bus_address);
      end
   end

   // Capture the item on accept
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff    <= req;
         idx_ff     <= req_idx;
         in_win_ff  <= req_in_win;
         key_bit_ff <= key_ent.mask;
      end
   end

   // Sweep address
   assign sweep_any  = cmd.sweep_all || cmd.sweep_vis;
   assign sweep_last = (sweep_cnt_ff == IW'(kmp_pkg::WINDOW_SIZE - 1));

   always_comb begin
      sweep_cnt_in = sweep_cnt_ff;
      if (sweep_any) begin
         sweep_cnt_in = sweep_last ? '0 : sweep_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
      end else begin
         sweep_cnt_ff <= sweep_cnt_in;
      end
   end

   assign status.sweep_last = sweep_last;
   assign status.clear_item = (item_ff.cmd == kmp_pkg::CMD_CLEAR);

   // Decode the captured command
   assign is_read  = (item_ff.cmd == kmp_pkg::CMD_READ);
   assign is_rp    = is_read || (item_ff.cmd == kmp_pkg::CMD_PEEK);
   assign is_key   = (item_ff.cmd == kmp_pkg::CMD_KEY);
   assign is_set   = (item_ff.cmd == kmp_pkg::CMD_SET);
   assign is_clear = (item_ff.cmd == kmp_pkg::CMD_CLEAR);

   // Read value: base with pressed bits cleared, unknown on ghosting
   always_comb begin
      st       = kmp_pkg::store_word_type'(store_rdata);
      single   = (st.pressed & (st.pressed - 8'd1)) == 8'd0;
      verified = st.known || kmp_pkg::idle_verified(item_ff.bus_address);
      value_ok = is_rp && in_win_ff && verified && single;
      base_sel = st.known ? st.base : kmp_pkg::IDLE_BASE;
   end

   // Modify the store entry for key events and set responses
   always_comb begin
      st_new = st;
      if (is_key) begin
         st_new.pressed = item_ff.key_down ? (st.pressed | key_bit_ff)
                                           : (st.pressed & ~key_bit_ff);
      end else begin
         st_new.base  = item_ff.response_byte;
         st_new.known = item_ff.response_known;
      end
   end

   // Store RAM: cleared by the reset sweep, written back on apply
   assign store_we    = cmd.sweep_all || (cmd.apply && in_win_ff && (is_key || is_set));
   assign store_waddr = cmd.sweep_all ? sweep_cnt_ff : idx_ff;
   assign store_wdata = cmd.sweep_all ? '0 : SW'(st_new);

   kmp_ram #(
      .WIDTH(SW),
      .DEPTH(kmp_pkg::WINDOW_SIZE)
   ) u_store_ram (
      .clock (clock),
      .we    (store_we),
      .waddr (store_waddr),
      .wdata (store_wdata),
      .re    (cmd.accept),
      .raddr (req_idx),
      .rdata (store_rdata)
   );

   // Visited RAM: cleared by either sweep, marked by a handled read
   assign count_read = cmd.apply && is_read && in_win_ff;
   assign vis_we     = sweep_any || (count_read && !vis_rdata);
   assign vis_waddr  = sweep_any ? sweep_cnt_ff : idx_ff;
   assign vis_wdata  = !sweep_any;

   kmp_ram #(
      .WIDTH(1),
      .DEPTH(kmp_pkg::WINDOW_SIZE)
   ) u_visited_ram (
      .clock (clock),
      .we    (vis_we),
      .waddr (vis_waddr),
      .wdata (vis_wdata),
      .re    (cmd.accept),
      .raddr (req_idx),
      .rdata (vis_rdata)
   );

   // Activity counters, saturating; both cleared by a clear-activity item
   always_comb begin
      attempts_in = attempts_ff;
      distinct_in = distinct_ff;
      if (cmd.apply && is_clear) begin
         attempts_in = '0;
         distinct_in = '0;
      end else if (count_read) begin
         if (attempts_ff != kmp_pkg::ATTEMPT_MAX) begin
            attempts_in = attempts_ff + 32'd1;
         end
         if (!vis_rdata && (distinct_ff != kmp_pkg::DISTINCT_MAX)) begin
            distinct_in = distinct_ff + 11'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attempts_ff <= '0;
         distinct_ff <= '0;
      end else begin
         attempts_ff <= attempts_in;
         distinct_ff <= distinct_in;
      end
   end

   // Response register, loaded on apply
   always_comb begin
      rsp_in.handled        = is_rp && in_win_ff;
      rsp_in.value_valid    = value_ok;
      rsp_in.read_byte      = value_ok ? (base_sel & ~st.pressed) : 8'd0;
      rsp_in.accepted       = in_win_ff && (is_key || is_set);
      rsp_in.attempt_count  = attempts_in;
      rsp_in.distinct_count = distinct_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire
